### sv/dirty_rectangle_tracker_defines.svh
// assertion macros for the dirty rectangle tracker
// included by the rtl files that carry concurrent assertions, no other dependencies
`ifndef DIRTY_RECTANGLE_TRACKER_DEFINES_SVH
`define DIRTY_RECTANGLE_TRACKER_DEFINES_SVH

// condition must hold at every edge outside reset
`define DRT_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define DRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### sv/drt_pkg.sv
// shared types, codes and constants of the dirty rectangle tracker
// no dependencies; imported by every rtl module of the block
`default_nettype none

package drt_pkg;

	localparam int unsigned COORD_BITS      = 11;
	localparam int unsigned MAX_PENDING_DEF = 16;
	localparam int unsigned CFG_DATA_BITS   = 11;

	typedef logic [COORD_BITS-1:0]    coord_t;
	typedef logic [2:0]               status_t;
	typedef logic [2:0]               reg_idx_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

	localparam coord_t COORD_MAX = '1;

	// result status codes
	localparam status_t ST_APPEND  = 3'd0;
	localparam status_t ST_DROP    = 3'd1;
	localparam status_t ST_REPLACE = 3'd2;
	localparam status_t ST_FULL    = 3'd3;
	localparam status_t ST_FLUSH   = 3'd4;

	// request function codes
	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	// configuration register indexes
	localparam reg_idx_t REG_X_SCALE  = 3'd0;
	localparam reg_idx_t REG_Y_SCALE  = 3'd1;
	localparam reg_idx_t REG_Y_OFFSET = 3'd2;
	localparam reg_idx_t REG_W_SCALE  = 3'd3;
	localparam reg_idx_t REG_H_SCALE  = 3'd4;
	localparam reg_idx_t REG_SCREEN_W = 3'd5;
	localparam reg_idx_t REG_SCREEN_H = 3'd6;

	typedef struct packed {
		logic       func;
		logic [8:0] virt_x;
		logic [7:0] virt_y;
		logic [6:0] virt_w;
		logic [7:0] virt_h;
	} req_t;

	typedef struct packed {
		status_t status;
		coord_t  rect_x;
		coord_t  rect_y;
		coord_t  rect_w;
		coord_t  rect_h;
		logic    rect_valid;
		logic    last;
	} rsp_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t w;
		coord_t h;
	} rect_t;

	// rectangle travelling down the cell row
	typedef struct packed {
		logic    valid;
		logic    done;
		status_t status;
		rect_t   rect;
	} tok_t;

	typedef struct packed {
		logic [2:0] x_scale;
		logic [2:0] y_scale;
		logic [7:0] y_offset;
		logic [2:0] w_scale;
		logic [2:0] h_scale;
		coord_t     screen_width;
		coord_t     screen_height;
	} cfg_t;

endpackage

`default_nettype wire

### sv/dirty_rectangle_tracker.sv
// top level of the dirty rectangle tracker: config registers, cell row, flush and output
// depends on drt_pkg, drt_scale, drt_cell and dirty_rectangle_tracker_defines.svh
//
// Keeps up to MAX_PENDING screen-update rectangles in a row of cells. An add
// request is scaled and clipped in drt_scale, then walks the row one cell per
// cycle. A flush with n stored rectangles gives n results at one per cycle while
// rsp_ready does not hold the output (one result when the table is empty), the
// entries moving towards the head of the row as they are sent. Items are
// worked one at a time; the response register lets a new request in while the
// previous result waits to be taken. Config writes are always accepted and
// must only be issued while no request is in progress.
`default_nettype none
`include "dirty_rectangle_tracker_defines.svh"

module dirty_rectangle_tracker #(
	parameter int unsigned MAX_PENDING = drt_pkg::MAX_PENDING_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  drt_pkg::req_t      req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output drt_pkg::rsp_t      rsp,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  drt_pkg::reg_idx_t  cfg_index,
	input  drt_pkg::cfg_data_t cfg_data
);
	import drt_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_PENDING + 1);

	cfg_t             cfg_q;
	logic             busy_q, fl_q, end_v_q, rsp_valid_q;
	logic [CNT_W-1:0] count_q, rem_q;
	tok_t             end_q;
	rsp_t             rsp_q, rsp_nxt;

	logic             accept, start_add, start_flush;
	logic             can_load, load, shift, item_done;
	tok_t             tok [MAX_PENDING+1];
	rect_t            ents [MAX_PENDING];
	logic [MAX_PENDING:0] tok_vld;

	assign accept      = req_valid && req_ready;
	assign start_add   = accept && req.func == FUNC_ADD;
	assign start_flush = accept && req.func == FUNC_FLUSH;
	assign req_ready   = !busy_q;
	assign cfg_ready   = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_scale       <= 3'd2;
			cfg_q.y_scale       <= 3'd2;
			cfg_q.y_offset      <= 8'd0;
			cfg_q.w_scale       <= 3'd2;
			cfg_q.h_scale       <= 3'd2;
			cfg_q.screen_width  <= coord_t'(640);
			cfg_q.screen_height <= coord_t'(400);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_X_SCALE:  cfg_q.x_scale       <= cfg_data[2:0];
				REG_Y_SCALE:  cfg_q.y_scale       <= cfg_data[2:0];
				REG_Y_OFFSET: cfg_q.y_offset      <= cfg_data[7:0];
				REG_W_SCALE:  cfg_q.w_scale       <= cfg_data[2:0];
				REG_H_SCALE:  cfg_q.h_scale       <= cfg_data[2:0];
				REG_SCREEN_W: cfg_q.screen_width  <= cfg_data[COORD_BITS-1:0];
				REG_SCREEN_H: cfg_q.screen_height <= cfg_data[COORD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// scaling and clipping front end
	drt_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_add),
		.req    (req),
		.cfg    (cfg_q),
		.tok    (tok[0])
	);

	// row of cells
	for (genvar g = 0; g < MAX_PENDING; g++) begin : g_cell
		rect_t nbr;
		if (g == MAX_PENDING - 1) begin : g_tail
			assign nbr = ents[g];
		end else begin : g_mid
			assign nbr = ents[g+1];
		end

		drt_cell #(
			.IDX   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1]),
			.count   (count_q),
			.shift   (shift),
			.nbr     (nbr),
			.ent     (ents[g])
		);
	end

	for (genvar g = 0; g <= MAX_PENDING; g++) begin : g_vld
		assign tok_vld[g] = tok[g].valid;
	end

	// next response and load control
	assign can_load = !rsp_valid_q || rsp_ready;

	always_comb begin
		rsp_nxt = '0;
		if (end_v_q) begin
			rsp_nxt.status     = end_q.status;
			rsp_nxt.rect_x     = end_q.rect.x;
			rsp_nxt.rect_y     = end_q.rect.y;
			rsp_nxt.rect_w     = end_q.rect.w;
			rsp_nxt.rect_h     = end_q.rect.h;
			rsp_nxt.rect_valid = 1'b1;
			rsp_nxt.last       = 1'b1;
		end else if (rem_q == '0) begin
			rsp_nxt.status     = ST_FLUSH;
			rsp_nxt.last       = 1'b1;
		end else begin
			rsp_nxt.status     = ST_FLUSH;
			rsp_nxt.rect_x     = ents[0].x;
			rsp_nxt.rect_y     = ents[0].y;
			rsp_nxt.rect_w     = ents[0].w;
			rsp_nxt.rect_h     = ents[0].h;
			rsp_nxt.rect_valid = 1'b1;
			rsp_nxt.last       = rem_q == CNT_W'(1);
		end
	end

	assign load      = can_load && (end_v_q || fl_q);
	assign shift     = load && fl_q && rem_q != '0;
	assign item_done = load && rsp_nxt.last;

	// item control: busy, flush walk, pending count, end of row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fl_q    <= 1'b0;
			end_v_q <= 1'b0;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (item_done) begin
				busy_q <= 1'b0;
			end

			if (start_flush) begin
				fl_q  <= 1'b1;
				rem_q <= count_q;
			end else if (load && fl_q) begin
				if (rsp_nxt.last) begin
					fl_q <= 1'b0;
				end
				if (shift) begin
					rem_q <= rem_q - CNT_W'(1);
				end
			end

			if (tok[MAX_PENDING].valid) begin
				end_v_q <= 1'b1;
			end else if (load && end_v_q) begin
				end_v_q <= 1'b0;
			end

			if (tok[MAX_PENDING].valid && tok[MAX_PENDING].status == ST_APPEND) begin
				count_q <= count_q + CNT_W'(1);
			end else if (item_done && fl_q) begin
				count_q <= '0;
			end
		end
	end

	// end of row holding register
	always_ff @(posedge clk) begin
		if (tok[MAX_PENDING].valid) begin
			end_q <= tok[MAX_PENDING];
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	`DRT_ASSERT_ALWAYS(a_one_in_flight, clk, arst_n,
		$countones({tok_vld, end_v_q, fl_q}) <= 1, "more than one item in flight")
	`DRT_ASSERT_IMP(a_idle_empty, clk, arst_n, !busy_q,
		tok_vld == '0 && !end_v_q && !fl_q, "work in flight while idle")
	`DRT_ASSERT_ALWAYS(a_count_bound, clk, arst_n,
		count_q <= CNT_W'(MAX_PENDING), "pending count beyond table depth")
	`DRT_ASSERT_NXT(a_append_count, clk, arst_n,
		tok[MAX_PENDING].valid && tok[MAX_PENDING].status == ST_APPEND,
		count_q == $past(count_q) + CNT_W'(1), "append did not grow the table")

endmodule

`default_nettype wire

### sv/drt_scale.sv
// scaling and clipping of a new rectangle, two register stages
// depends on drt_pkg; feeds the first cell of the row
`default_nettype none

module drt_scale (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  drt_pkg::req_t req,
	input  drt_pkg::cfg_t cfg,
	output drt_pkg::tok_t tok
);
	import drt_pkg::*;

	logic [11:0] x_prod, y_sum, w_prod;
	coord_t      h_prod;

	logic        v_s1;
	coord_t      x_s1, y_s1, h_s1;
	logic [11:0] w_s1;

	coord_t      w_clip, h_clip;
	logic        v_s2;
	tok_t        tok_s2;

	// clipped length of a span starting at pos
	function automatic coord_t clip_len(coord_t pos, logic [11:0] len, coord_t lim);
		logic [12:0] span_end;
		span_end = 13'(pos) + 13'(len);
		if (span_end <= 13'(lim))
			return len[COORD_BITS-1:0];
		else if (pos >= lim)
			return '0;
		else
			return lim - pos;
	endfunction

	// virtual to screen units
	assign x_prod = 12'(req.virt_x) * 12'(cfg.x_scale);
	assign y_sum  = 12'(req.virt_y) * 12'(cfg.y_scale) + 12'(cfg.y_offset);
	assign w_prod = {3'b000, req.virt_w, 2'b00} * 12'(cfg.w_scale);
	assign h_prod = coord_t'(req.virt_h) * coord_t'(cfg.h_scale);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	// stage 1 payload with coordinate saturation
	always_ff @(posedge clk) begin
		if (start) begin
			x_s1 <= (x_prod > 12'(COORD_MAX)) ? COORD_MAX : x_prod[COORD_BITS-1:0];
			y_s1 <= (y_sum > 12'(COORD_MAX)) ? COORD_MAX : y_sum[COORD_BITS-1:0];
			w_s1 <= w_prod;
			h_s1 <= h_prod;
		end
	end

	// clip to the screen, an empty side empties both
	always_comb begin
		w_clip = clip_len(x_s1, w_s1, cfg.screen_width);
		h_clip = clip_len(y_s1, 12'(h_s1), cfg.screen_height);
		if (w_clip == '0 || h_clip == '0) begin
			w_clip = '0;
			h_clip = '0;
		end
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	// stage 2 payload, status starts as full until a cell decides
	always_ff @(posedge clk) begin
		if (v_s1) begin
			tok_s2.valid  <= 1'b1;
			tok_s2.done   <= 1'b0;
			tok_s2.status <= ST_FULL;
			tok_s2.rect   <= '{x: x_s1, y: y_s1, w: w_clip, h: h_clip};
		end
	end

	always_comb begin
		tok       = tok_s2;
		tok.valid = v_s2;
	end

endmodule

`default_nettype wire

### sv/drt_cell.sv
// one cell of the pending rectangle row: holds one entry and compares it
// with the passing rectangle; depends on drt_pkg
`default_nettype none

module drt_cell #(
	parameter int unsigned IDX   = 0,
	parameter int unsigned CNT_W = $clog2(drt_pkg::MAX_PENDING_DEF + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  drt_pkg::tok_t      tok_in,
	output drt_pkg::tok_t      tok_out,
	input  logic [CNT_W-1:0]   count,
	input  logic               shift,
	input  drt_pkg::rect_t     nbr,
	output drt_pkg::rect_t     ent
);
	import drt_pkg::*;

	rect_t             ent_q;
	tok_t              tok_nxt, tok_q;
	logic              valid_q;
	logic              wr;
	logic              occ, app, live;
	logic              enclosed, covers;
	logic [COORD_BITS:0] nr, nb, er, eb;

	// right and bottom edges
	assign nr = {1'b0, tok_in.rect.x} + {1'b0, tok_in.rect.w};
	assign nb = {1'b0, tok_in.rect.y} + {1'b0, tok_in.rect.h};
	assign er = {1'b0, ent_q.x} + {1'b0, ent_q.w};
	assign eb = {1'b0, ent_q.y} + {1'b0, ent_q.h};

	assign enclosed = tok_in.rect.x >= ent_q.x && tok_in.rect.y >= ent_q.y &&
			nr <= er && nb <= eb;
	assign covers = tok_in.rect.x <= ent_q.x && tok_in.rect.y <= ent_q.y &&
			nr >= er && nb >= eb;

	assign occ  = CNT_W'(IDX) < count;
	assign app  = CNT_W'(IDX) == count;
	assign live = tok_in.valid && !tok_in.done;

	// decision of this cell
	always_comb begin
		tok_nxt = tok_in;
		wr      = 1'b0;
		if (live && occ) begin
			if (enclosed) begin
				tok_nxt.done   = 1'b1;
				tok_nxt.status = ST_DROP;
			end else if (covers) begin
				wr             = 1'b1;
				tok_nxt.done   = 1'b1;
				tok_nxt.status = ST_REPLACE;
			end
		end else if (live && app) begin
			wr             = 1'b1;
			tok_nxt.done   = 1'b1;
			tok_nxt.status = ST_APPEND;
		end
	end

	// entry store, flush moves entries one cell towards the head
	always_ff @(posedge clk) begin
		if (shift) begin
			ent_q <= nbr;
		end else if (wr) begin
			ent_q <= tok_in.rect;
		end
	end

	// token register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	// token register payload
	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			tok_q <= tok_nxt;
		end
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

	assign ent = ent_q;

endmodule

`default_nettype wire
